>>> sv/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types, codes and constants of the bracket body scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

   // default parameter values
   localparam int NEST_DEPTH_DEF = 16;
   localparam int LINE_BITS_DEF  = 20;

   // fixed port widths
   localparam int FUNC_BITS     = 2;
   localparam int CHAR_BITS     = 8;
   localparam int IN_LINE_BITS  = 20;
   localparam int KIND_BITS     = 2;
   localparam int CODE_BITS     = 3;
   localparam int OUT_LINE_BITS = 20;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // request functions
   localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_CHAR  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_EOF   = 2'd2;

   // characters
   localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h27;
   localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;

   // classified operations
   localparam int OP_BITS = 4;
   typedef logic [OP_BITS-1:0] op_type;
   localparam op_type OP_NONE   = 4'd0;
   localparam op_type OP_START  = 4'd1;
   localparam op_type OP_EOF    = 4'd2;
   localparam op_type OP_NL     = 4'd3;
   localparam op_type OP_HASH   = 4'd4;
   localparam op_type OP_QUOTE  = 4'd5;
   localparam op_type OP_LBRACE = 4'd6;
   localparam op_type OP_LPAREN = 4'd7;
   localparam op_type OP_RPAREN = 4'd8;
   localparam op_type OP_RBRACE = 4'd9;
   localparam op_type OP_OTHER  = 4'd10;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_CHAR = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ERR  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_FAIL = 2'd3;

   // error codes
   localparam logic [CODE_BITS-1:0] ERR_NONE       = 3'd0;
   localparam logic [CODE_BITS-1:0] ERR_STRAY      = 3'd1;
   localparam logic [CODE_BITS-1:0] ERR_PAREN      = 3'd2;
   localparam logic [CODE_BITS-1:0] ERR_BRACE      = 3'd3;
   localparam logic [CODE_BITS-1:0] ERR_EOF_COMM   = 3'd4;
   localparam logic [CODE_BITS-1:0] ERR_EOF_STRING = 3'd5;
   localparam logic [CODE_BITS-1:0] ERR_DEEP       = 3'd6;

   // scan modes
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_IDLE    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_BODY    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_COMMENT = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_STRING  = 2'd3;

   typedef struct packed {
      op_type                  op;
      logic [CHAR_BITS-1:0]    ch;
      logic [IN_LINE_BITS-1:0] start_line;
   } item_type;

   function automatic logic [QPTR_BITS-1:0] next_qptr(input logic [QPTR_BITS-1:0] ptr);
      logic [QPTR_BITS-1:0] nxt;
      if (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

>>> sv/bbs_front.sv
// ----------------------------------------------------------------------------
// bbs_front
// Accepts request transfers, classifies each byte and queues the items.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [bbs_pkg::FUNC_BITS-1:0]       req_func,
   input  wire  [bbs_pkg::CHAR_BITS-1:0]       req_ch,
   input  wire  [bbs_pkg::IN_LINE_BITS-1:0]    req_start_line,
   output logic                                q_valid,
   output bbs_pkg::item_type                   q_item,
   input  wire                                 q_pop
);

   bbs_pkg::item_type               entry_ff [bbs_pkg::QUEUE_DEPTH];
   logic [bbs_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bbs_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bbs_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   bbs_pkg::item_type               cls_item;
   logic                            push;
   logic                            pop;

   always_comb begin
      cls_item.ch         = req_ch;
      cls_item.start_line = req_start_line;
      unique case (req_func)
         bbs_pkg::FUNC_START: cls_item.op = bbs_pkg::OP_START;
         bbs_pkg::FUNC_EOF:   cls_item.op = bbs_pkg::OP_EOF;
         bbs_pkg::FUNC_CHAR: begin
            unique case (req_ch)
               bbs_pkg::CH_NL:     cls_item.op = bbs_pkg::OP_NL;
               bbs_pkg::CH_HASH:   cls_item.op = bbs_pkg::OP_HASH;
               bbs_pkg::CH_QUOTE:  cls_item.op = bbs_pkg::OP_QUOTE;
               bbs_pkg::CH_LBRACE: cls_item.op = bbs_pkg::OP_LBRACE;
               bbs_pkg::CH_LPAREN: cls_item.op = bbs_pkg::OP_LPAREN;
               bbs_pkg::CH_RPAREN: cls_item.op = bbs_pkg::OP_RPAREN;
               bbs_pkg::CH_RBRACE: cls_item.op = bbs_pkg::OP_RBRACE;
               default:            cls_item.op = bbs_pkg::OP_OTHER;
            endcase
         end
         default:             cls_item.op = bbs_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == bbs_pkg::QCNT_BITS'(bbs_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid & ~req_stall;
   assign pop       = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = push ? bbs_pkg::next_qptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bbs_pkg::next_qptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

`default_nettype wire

>>> sv/bbs_back.sv
// ----------------------------------------------------------------------------
// bbs_back
// Scan state, nesting stacks, drain sequencer and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_back #(
   parameter int NEST_DEPTH = bbs_pkg::NEST_DEPTH_DEF,
   parameter int LINE_BITS  = bbs_pkg::LINE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 q_valid,
   input  bbs_pkg::item_type                   q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [bbs_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [bbs_pkg::CHAR_BITS-1:0]       rsp_out_char,
   output logic [bbs_pkg::CODE_BITS-1:0]       rsp_error_code,
   output logic [bbs_pkg::OUT_LINE_BITS-1:0]   rsp_error_line,
   output logic                                rsp_last
);

   localparam int DEPTH_BITS = $clog2(NEST_DEPTH + 1);
   localparam int IDX_BITS   = $clog2(NEST_DEPTH);

   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_DRAIN_P = 2'd1;
   localparam logic [1:0] ST_DRAIN_B = 2'd2;
   localparam logic [1:0] ST_FINAL   = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [bbs_pkg::MODE_BITS-1:0]     mode_ff, mode_in;
   logic [LINE_BITS-1:0]              line_ff, line_in;
   logic [DEPTH_BITS-1:0]             pdepth_ff, pdepth_in;
   logic [DEPTH_BITS-1:0]             bdepth_ff, bdepth_in;
   logic                              drain_b_ff, drain_b_in;
   logic [bbs_pkg::KIND_BITS-1:0]     fin_kind_ff, fin_kind_in;
   logic [LINE_BITS-1:0]              pstack_ff [NEST_DEPTH];
   logic [LINE_BITS-1:0]              bstack_ff [NEST_DEPTH];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bbs_pkg::KIND_BITS-1:0]     kind_ff;
   logic [bbs_pkg::CHAR_BITS-1:0]     char_ff;
   logic [bbs_pkg::CODE_BITS-1:0]     code_ff;
   logic [bbs_pkg::OUT_LINE_BITS-1:0] eline_ff;
   logic                              last_ff;

   logic                              out_free;
   logic                              emit;
   logic [bbs_pkg::KIND_BITS-1:0]     e_kind;
   logic [bbs_pkg::CHAR_BITS-1:0]     e_char;
   logic [bbs_pkg::CODE_BITS-1:0]     e_code;
   logic [LINE_BITS-1:0]              e_line;
   logic                              e_last;
   logic                              p_we, b_we;
   logic [IDX_BITS-1:0]               p_widx, b_widx;
   logic [LINE_BITS-1:0]              b_wdata;
   logic [LINE_BITS-1:0]              line_inc;
   logic [LINE_BITS-1:0]              start_val;
   logic [LINE_BITS+bbs_pkg::IN_LINE_BITS-1:0]  start_ext;
   logic [LINE_BITS+bbs_pkg::OUT_LINE_BITS-1:0] eline_ext;
   logic [IDX_BITS-1:0]               p_top, b_top;
   logic [DEPTH_BITS-1:0]             pdepth_dec, bdepth_dec;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign line_inc   = (&line_ff) ? line_ff : line_ff + 1'b1;
   assign start_ext  = {{LINE_BITS{1'b0}}, q_item.start_line};
   assign start_val  = start_ext[LINE_BITS-1:0];
   assign pdepth_dec = pdepth_ff - 1'b1;
   assign bdepth_dec = bdepth_ff - 1'b1;
   assign p_top      = pdepth_dec[IDX_BITS-1:0];
   assign b_top      = bdepth_dec[IDX_BITS-1:0];
   assign eline_ext  = {{bbs_pkg::OUT_LINE_BITS{1'b0}}, e_line};

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      line_in     = line_ff;
      pdepth_in   = pdepth_ff;
      bdepth_in   = bdepth_ff;
      drain_b_in  = drain_b_ff;
      fin_kind_in = fin_kind_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      e_kind      = bbs_pkg::KIND_CHAR;
      e_char      = '0;
      e_code      = bbs_pkg::ERR_NONE;
      e_line      = '0;
      e_last      = 1'b1;
      p_we        = 1'b0;
      b_we        = 1'b0;
      p_widx      = pdepth_ff[IDX_BITS-1:0];
      b_widx      = bdepth_ff[IDX_BITS-1:0];
      b_wdata     = line_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               priority if (q_item.op == bbs_pkg::OP_START) begin
                  line_in   = start_val;
                  pdepth_in = '0;
                  bdepth_in = DEPTH_BITS'(1);
                  b_we      = 1'b1;
                  b_widx    = '0;
                  b_wdata   = start_val;
                  mode_in   = bbs_pkg::MODE_BODY;
               end else if (q_item.op == bbs_pkg::OP_NONE) begin
               end else if (q_item.op == bbs_pkg::OP_EOF) begin
                  if (mode_ff == bbs_pkg::MODE_BODY) begin
                     drain_b_in  = 1'b1;
                     fin_kind_in = bbs_pkg::KIND_FAIL;
                     state_in    = ST_DRAIN_P;
                     mode_in     = bbs_pkg::MODE_IDLE;
                  end else if (mode_ff != bbs_pkg::MODE_IDLE) begin
                     emit        = 1'b1;
                     e_kind      = bbs_pkg::KIND_ERR;
                     e_code      = (mode_ff == bbs_pkg::MODE_COMMENT) ?
                                   bbs_pkg::ERR_EOF_COMM : bbs_pkg::ERR_EOF_STRING;
                     e_line      = line_ff;
                     e_last      = 1'b0;
                     fin_kind_in = bbs_pkg::KIND_FAIL;
                     state_in    = ST_FINAL;
                     mode_in     = bbs_pkg::MODE_IDLE;
                  end
               end else if (mode_ff == bbs_pkg::MODE_COMMENT) begin
                  if (q_item.op == bbs_pkg::OP_NL) begin
                     emit    = 1'b1;
                     e_char  = bbs_pkg::CH_SPACE;
                     line_in = line_inc;
                     mode_in = bbs_pkg::MODE_BODY;
                  end
               end else if (mode_ff == bbs_pkg::MODE_STRING) begin
                  emit   = 1'b1;
                  e_char = q_item.ch;
                  if (q_item.op == bbs_pkg::OP_NL) begin
                     line_in = line_inc;
                  end else if (q_item.op == bbs_pkg::OP_QUOTE) begin
                     mode_in = bbs_pkg::MODE_BODY;
                  end
               end else if (mode_ff == bbs_pkg::MODE_BODY) begin
                  unique case (q_item.op)
                     bbs_pkg::OP_NL: begin
                        emit    = 1'b1;
                        e_char  = bbs_pkg::CH_SPACE;
                        line_in = line_inc;
                     end
                     bbs_pkg::OP_HASH: begin
                        mode_in = bbs_pkg::MODE_COMMENT;
                     end
                     bbs_pkg::OP_QUOTE: begin
                        emit    = 1'b1;
                        e_char  = q_item.ch;
                        mode_in = bbs_pkg::MODE_STRING;
                     end
                     bbs_pkg::OP_LBRACE: begin
                        emit = 1'b1;
                        if (bdepth_ff == DEPTH_BITS'(NEST_DEPTH)) begin
                           e_kind      = bbs_pkg::KIND_ERR;
                           e_code      = bbs_pkg::ERR_DEEP;
                           e_line      = line_ff;
                           e_last      = 1'b0;
                           fin_kind_in = bbs_pkg::KIND_FAIL;
                           state_in    = ST_FINAL;
                           mode_in     = bbs_pkg::MODE_IDLE;
                        end else begin
                           e_char    = q_item.ch;
                           b_we      = 1'b1;
                           bdepth_in = bdepth_ff + 1'b1;
                        end
                     end
                     bbs_pkg::OP_LPAREN: begin
                        emit = 1'b1;
                        if (pdepth_ff == DEPTH_BITS'(NEST_DEPTH)) begin
                           e_kind      = bbs_pkg::KIND_ERR;
                           e_code      = bbs_pkg::ERR_DEEP;
                           e_line      = line_ff;
                           e_last      = 1'b0;
                           fin_kind_in = bbs_pkg::KIND_FAIL;
                           state_in    = ST_FINAL;
                           mode_in     = bbs_pkg::MODE_IDLE;
                        end else begin
                           e_char    = q_item.ch;
                           p_we      = 1'b1;
                           pdepth_in = pdepth_ff + 1'b1;
                        end
                     end
                     bbs_pkg::OP_RPAREN: begin
                        emit = 1'b1;
                        if (pdepth_ff == '0) begin
                           e_kind = bbs_pkg::KIND_ERR;
                           e_code = bbs_pkg::ERR_STRAY;
                           e_line = line_ff;
                        end else begin
                           e_char    = q_item.ch;
                           pdepth_in = pdepth_dec;
                        end
                     end
                     bbs_pkg::OP_RBRACE: begin
                        if (bdepth_ff <= DEPTH_BITS'(1)) begin
                           bdepth_in = '0;
                           mode_in   = bbs_pkg::MODE_IDLE;
                           if (pdepth_ff != '0) begin
                              drain_b_in  = 1'b0;
                              fin_kind_in = bbs_pkg::KIND_DONE;
                              state_in    = ST_DRAIN_P;
                           end else begin
                              emit   = 1'b1;
                              e_kind = bbs_pkg::KIND_DONE;
                           end
                        end else begin
                           emit      = 1'b1;
                           e_char    = q_item.ch;
                           bdepth_in = bdepth_dec;
                        end
                     end
                     default: begin
                        emit   = 1'b1;
                        e_char = q_item.ch;
                     end
                  endcase
               end else begin
                  // idle: dropped
               end
            end
         end
         ST_DRAIN_P: begin
            if (out_free) begin
               if (pdepth_ff != '0) begin
                  emit      = 1'b1;
                  e_kind    = bbs_pkg::KIND_ERR;
                  e_code    = bbs_pkg::ERR_PAREN;
                  e_line    = pstack_ff[p_top];
                  e_last    = 1'b0;
                  pdepth_in = pdepth_dec;
               end else begin
                  state_in = drain_b_ff ? ST_DRAIN_B : ST_FINAL;
               end
            end
         end
         ST_DRAIN_B: begin
            if (out_free) begin
               if (bdepth_ff != '0) begin
                  emit      = 1'b1;
                  e_kind    = bbs_pkg::KIND_ERR;
                  e_code    = bbs_pkg::ERR_BRACE;
                  e_line    = bstack_ff[b_top];
                  e_last    = 1'b0;
                  bdepth_in = bdepth_dec;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         default: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = fin_kind_ff;
               state_in = ST_RUN;
            end
         end
      endcase

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         mode_ff      <= bbs_pkg::MODE_IDLE;
         line_ff      <= '0;
         pdepth_ff    <= '0;
         bdepth_ff    <= '0;
         drain_b_ff   <= 1'b0;
         fin_kind_ff  <= bbs_pkg::KIND_FAIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         pdepth_ff    <= pdepth_in;
         bdepth_ff    <= bdepth_in;
         drain_b_ff   <= drain_b_in;
         fin_kind_ff  <= fin_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stacks and response payload: no reset
   always_ff @(posedge clock) begin
      if (p_we) begin
         pstack_ff[p_widx] <= line_ff;
      end
      if (b_we) begin
         bstack_ff[b_widx] <= b_wdata;
      end
      if (out_free && emit) begin
         kind_ff  <= e_kind;
         char_ff  <= e_char;
         code_ff  <= e_code;
         eline_ff <= eline_ext[bbs_pkg::OUT_LINE_BITS-1:0];
         last_ff  <= e_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_error_code = code_ff;
   assign rsp_error_line = eline_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

>>> sv/bracket_body_scanner_top.sv
// ----------------------------------------------------------------------------
// bracket_body_scanner_top
// Throughput: one item per cycle while the response side does not stall; a drain
// handles the item, then reports each stack entry, passes through each stack
// phase and gives the outcome; an overflow or end of input in a comment or string
// gives an error and then the outcome.
// Reset: synchronous, clears mode, line, depths and queue; stacks keep contents.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_body_scanner_top #(
   parameter int NEST_DEPTH = bbs_pkg::NEST_DEPTH_DEF,
   parameter int LINE_BITS  = bbs_pkg::LINE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [bbs_pkg::FUNC_BITS-1:0]       req_func,
   input  wire  [bbs_pkg::CHAR_BITS-1:0]       req_ch,
   input  wire  [bbs_pkg::IN_LINE_BITS-1:0]    req_start_line,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [bbs_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [bbs_pkg::CHAR_BITS-1:0]       rsp_out_char,
   output logic [bbs_pkg::CODE_BITS-1:0]       rsp_error_code,
   output logic [bbs_pkg::OUT_LINE_BITS-1:0]   rsp_error_line,
   output logic                                rsp_last
);

   logic              q_valid;
   logic              q_pop;
   bbs_pkg::item_type q_item;

   bbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_ch         (req_ch),
      .req_start_line (req_start_line),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   bbs_back #(
      .NEST_DEPTH (NEST_DEPTH),
      .LINE_BITS  (LINE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_char   (rsp_out_char),
      .rsp_error_code (rsp_error_code),
      .rsp_error_line (rsp_error_line),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
